// ===== rtl/hsv_to_rgb_converter_macros.svh =====
// Assertion helpers for the color converter.
`ifndef HSV_TO_RGB_CONVERTER_MACROS_SVH
`define HSV_TO_RGB_CONVERTER_MACROS_SVH

// Checked only while out of reset.
`define HSVC_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included.
`define HSVC_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/hsvc_pkg.sv =====
`timescale 1ns / 1ps

package hsvc_pkg;

   localparam int unsigned HUE_W      = 9;
   localparam int unsigned OUT_W      = 8;
   localparam int unsigned REM_W      = 6;
   localparam int unsigned HUE_TURN   = 360;
   localparam int unsigned SECTOR_DEG = 60;

   typedef logic [HUE_W-1:0] hue_type;
   typedef logic [OUT_W-1:0] chan_type;
   typedef logic [REM_W-1:0] rem_type;

   typedef enum logic [2:0] {
      SEC_RED     = 3'd0,
      SEC_YELLOW  = 3'd1,
      SEC_GREEN   = 3'd2,
      SEC_CYAN    = 3'd3,
      SEC_BLUE    = 3'd4,
      SEC_MAGENTA = 3'd5
   } sector_type;

   // First hue of sector k.
   function automatic hue_type sector_start(input int unsigned k);
      return hue_type'(SECTOR_DEG * k);
   endfunction

endpackage

// ===== rtl/hsvc_channels.sv =====
`timescale 1ns / 1ps

interface hsvc_req_if #(parameter int unsigned FRAC_BITS = 8);
   logic                valid;
   logic                ready;
   hsvc_pkg::hue_type   hue;
   logic [FRAC_BITS:0]  saturation;
   logic [FRAC_BITS:0]  brightness;

   modport source (output valid, output hue, output saturation, output brightness,
                   input ready);
   modport sink   (input valid, input hue, input saturation, input brightness,
                   output ready);
endinterface

interface hsvc_rsp_if;
   logic                valid;
   logic                ready;
   hsvc_pkg::chan_type  red_out;
   logic [7:0]          green_out;
   logic [7:0]          blue_out;

   modport source (output valid, output red_out, output green_out, output blue_out,
                   input ready);
   modport sink   (input valid, input red_out, input green_out, input blue_out,
                   output ready);
endinterface

// ===== rtl/hsvc_sector.sv =====
`timescale 1ns / 1ps

module hsvc_sector #(
   parameter int unsigned FRAC_BITS = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  hsvc_pkg::hue_type    hue,
   input  logic [FRAC_BITS:0]   saturation,
   input  logic [FRAC_BITS:0]   brightness,
   output logic                 out_valid,
   input  logic                 out_ready,
   output hsvc_pkg::sector_type sector,
   output hsvc_pkg::rem_type    rem,
   output logic [FRAC_BITS:0]   sat,
   output logic [FRAC_BITS:0]   val
);

   localparam logic [FRAC_BITS:0] ONE = (FRAC_BITS+1)'(1) << FRAC_BITS;

   logic                 valid_ff, valid_in, load;
   hsvc_pkg::hue_type    hue_wrap, base, rem_full;
   hsvc_pkg::sector_type sector_ff, sector_in;
   hsvc_pkg::rem_type    rem_ff, rem_in;
   logic [FRAC_BITS:0]   sat_ff, sat_in, val_ff, val_in;

   always_comb begin
      hue_wrap = (hue >= hsvc_pkg::hue_type'(hsvc_pkg::HUE_TURN))
               ? hue - hsvc_pkg::hue_type'(hsvc_pkg::HUE_TURN) : hue;
      priority if (hue_wrap >= hsvc_pkg::sector_start(5)) begin
         sector_in = hsvc_pkg::SEC_MAGENTA;
         base      = hsvc_pkg::sector_start(5);
      end else if (hue_wrap >= hsvc_pkg::sector_start(4)) begin
         sector_in = hsvc_pkg::SEC_BLUE;
         base      = hsvc_pkg::sector_start(4);
      end else if (hue_wrap >= hsvc_pkg::sector_start(3)) begin
         sector_in = hsvc_pkg::SEC_CYAN;
         base      = hsvc_pkg::sector_start(3);
      end else if (hue_wrap >= hsvc_pkg::sector_start(2)) begin
         sector_in = hsvc_pkg::SEC_GREEN;
         base      = hsvc_pkg::sector_start(2);
      end else if (hue_wrap >= hsvc_pkg::sector_start(1)) begin
         sector_in = hsvc_pkg::SEC_YELLOW;
         base      = hsvc_pkg::sector_start(1);
      end else begin
         sector_in = hsvc_pkg::SEC_RED;
         base      = hsvc_pkg::sector_start(0);
      end
      rem_full = hue_wrap - base;
      rem_in   = rem_full[hsvc_pkg::REM_W-1:0];
      // anything with the top bit set is at or above one
      sat_in   = saturation[FRAC_BITS] ? ONE : saturation;
      val_in   = brightness[FRAC_BITS] ? ONE : brightness;
      in_ready = !valid_ff || out_ready;
      load     = in_valid && in_ready;
      valid_in = in_ready ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         sector_ff <= sector_in;
         rem_ff    <= rem_in;
         sat_ff    <= sat_in;
         val_ff    <= val_in;
      end
   end

   assign out_valid = valid_ff;
   assign sector    = sector_ff;
   assign rem       = rem_ff;
   assign sat       = sat_ff;
   assign val       = val_ff;

endmodule

// ===== rtl/hsvc_terms.sv =====
`timescale 1ns / 1ps

module hsvc_terms #(
   parameter int unsigned FRAC_BITS = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  hsvc_pkg::sector_type  sector,
   input  hsvc_pkg::rem_type     rem,
   input  logic [FRAC_BITS:0]    sat,
   input  logic [FRAC_BITS:0]    val,
   output logic                  out_valid,
   input  logic                  out_ready,
   output hsvc_pkg::sector_type  sector_o,
   output hsvc_pkg::chan_type    cv,
   output logic [FRAC_BITS+5:0]  wq,
   output logic [FRAC_BITS+5:0]  wt,
   output logic [FRAC_BITS:0]    oms,
   output logic [FRAC_BITS+4:0]  v17,
   output logic [FRAC_BITS+7:0]  v255
);

   localparam int unsigned IN_W   = FRAC_BITS + 1;
   localparam int unsigned SR_W   = IN_W + hsvc_pkg::REM_W;
   localparam int unsigned W_W    = FRAC_BITS + 6;
   localparam int unsigned V17_W  = FRAC_BITS + 5;
   localparam int unsigned V255_W = FRAC_BITS + 8;
   localparam logic [IN_W-1:0]   ONE     = IN_W'(1) << FRAC_BITS;
   localparam logic [W_W-1:0]    FULL_W  = W_W'(hsvc_pkg::SECTOR_DEG) << FRAC_BITS;
   localparam logic [V255_W-1:0] CV_HALF = V255_W'(1) << (FRAC_BITS - 1);

   logic                 valid_ff, valid_in, load;
   hsvc_pkg::rem_type    rem_t;
   logic [SR_W-1:0]      sr_q, sr_t;
   logic [V255_W-1:0]    cv_sum;
   hsvc_pkg::sector_type sector_ff;
   hsvc_pkg::chan_type   cv_ff, cv_in;
   logic [W_W-1:0]       wq_ff, wq_in, wt_ff, wt_in;
   logic [IN_W-1:0]      oms_ff, oms_in;
   logic [V17_W-1:0]     v17_ff, v17_in;
   logic [V255_W-1:0]    v255_ff, v255_in;

   // Weights over a common 60*ONE scale: wq = 60*ONE - s*rem, wt = 60*ONE - s*(60-rem).
   // Since 255/60 = 17/4, the later products only need a power-of-two rounding shift.
   always_comb begin
      rem_t    = hsvc_pkg::rem_type'(hsvc_pkg::SECTOR_DEG) - rem;
      sr_q     = SR_W'(sat) * SR_W'(rem);
      sr_t     = SR_W'(sat) * SR_W'(rem_t);
      wq_in    = FULL_W - sr_q[W_W-1:0];
      wt_in    = FULL_W - sr_t[W_W-1:0];
      oms_in   = ONE - sat;
      v17_in   = (V17_W'(val) << 4) + V17_W'(val);
      v255_in  = (V255_W'(val) << 8) - V255_W'(val);
      cv_sum   = v255_in + CV_HALF;
      cv_in    = cv_sum[FRAC_BITS +: hsvc_pkg::OUT_W];
      in_ready = !valid_ff || out_ready;
      load     = in_valid && in_ready;
      valid_in = in_ready ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         sector_ff <= sector;
         cv_ff     <= cv_in;
         wq_ff     <= wq_in;
         wt_ff     <= wt_in;
         oms_ff    <= oms_in;
         v17_ff    <= v17_in;
         v255_ff   <= v255_in;
      end
   end

   assign out_valid = valid_ff;
   assign sector_o  = sector_ff;
   assign cv        = cv_ff;
   assign wq        = wq_ff;
   assign wt        = wt_ff;
   assign oms       = oms_ff;
   assign v17       = v17_ff;
   assign v255      = v255_ff;

endmodule

// ===== rtl/hsvc_mult.sv =====
`timescale 1ns / 1ps

module hsvc_mult #(
   parameter int unsigned FRAC_BITS = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  hsvc_pkg::sector_type   sector,
   input  hsvc_pkg::chan_type     cv,
   input  logic [FRAC_BITS+5:0]   wq,
   input  logic [FRAC_BITS+5:0]   wt,
   input  logic [FRAC_BITS:0]     oms,
   input  logic [FRAC_BITS+4:0]   v17,
   input  logic [FRAC_BITS+7:0]   v255,
   output logic                   out_valid,
   input  logic                   out_ready,
   output hsvc_pkg::sector_type   sector_o,
   output hsvc_pkg::chan_type     cv_o,
   output logic [2*FRAC_BITS+10:0] pq,
   output logic [2*FRAC_BITS+10:0] pt,
   output logic [2*FRAC_BITS+8:0]  pp
);

   localparam int unsigned PQ_W = 2 * FRAC_BITS + 11;
   localparam int unsigned PP_W = 2 * FRAC_BITS + 9;

   logic                 valid_ff, valid_in, load;
   hsvc_pkg::sector_type sector_ff;
   hsvc_pkg::chan_type   cv_ff;
   logic [PQ_W-1:0]      pq_ff, pq_in, pt_ff, pt_in;
   logic [PP_W-1:0]      pp_ff, pp_in;

   always_comb begin
      pq_in    = PQ_W'(v17) * PQ_W'(wq);
      pt_in    = PQ_W'(v17) * PQ_W'(wt);
      pp_in    = PP_W'(v255) * PP_W'(oms);
      in_ready = !valid_ff || out_ready;
      load     = in_valid && in_ready;
      valid_in = in_ready ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         sector_ff <= sector;
         cv_ff     <= cv;
         pq_ff     <= pq_in;
         pt_ff     <= pt_in;
         pp_ff     <= pp_in;
      end
   end

   assign out_valid = valid_ff;
   assign sector_o  = sector_ff;
   assign cv_o      = cv_ff;
   assign pq        = pq_ff;
   assign pt        = pt_ff;
   assign pp        = pp_ff;

endmodule

// ===== rtl/hsvc_route.sv =====
`timescale 1ns / 1ps

module hsvc_route #(
   parameter int unsigned FRAC_BITS = 8
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  hsvc_pkg::sector_type    sector,
   input  hsvc_pkg::chan_type      cv,
   input  logic [2*FRAC_BITS+10:0] pq,
   input  logic [2*FRAC_BITS+10:0] pt,
   input  logic [2*FRAC_BITS+8:0]  pp,
   output logic                    out_valid,
   input  logic                    out_ready,
   output hsvc_pkg::chan_type      red,
   output hsvc_pkg::chan_type      green,
   output hsvc_pkg::chan_type      blue
);

   localparam int unsigned PQ_W = 2 * FRAC_BITS + 11;
   localparam int unsigned PP_W = 2 * FRAC_BITS + 9;
   localparam logic [PQ_W-1:0] Q_HALF = PQ_W'(1) << (2 * FRAC_BITS + 1);
   localparam logic [PP_W-1:0] P_HALF = PP_W'(1) << (2 * FRAC_BITS - 1);

   logic               valid_ff, valid_in, load;
   logic [PQ_W-1:0]    cq_sum, ct_sum;
   logic [PP_W-1:0]    cp_sum;
   hsvc_pkg::chan_type cq, ct, cp;
   hsvc_pkg::chan_type red_ff, red_in, green_ff, green_in, blue_ff, blue_in;

   // round half up: add half of the divisor, then drop the fraction bits
   always_comb begin
      cq_sum = pq + Q_HALF;
      ct_sum = pt + Q_HALF;
      cp_sum = pp + P_HALF;
      cq     = cq_sum[2*FRAC_BITS+2 +: hsvc_pkg::OUT_W];
      ct     = ct_sum[2*FRAC_BITS+2 +: hsvc_pkg::OUT_W];
      cp     = cp_sum[2*FRAC_BITS +: hsvc_pkg::OUT_W];
      unique case (sector)
         hsvc_pkg::SEC_RED: begin
            red_in = cv; green_in = ct; blue_in = cp;
         end
         hsvc_pkg::SEC_YELLOW: begin
            red_in = cq; green_in = cv; blue_in = cp;
         end
         hsvc_pkg::SEC_GREEN: begin
            red_in = cp; green_in = cv; blue_in = ct;
         end
         hsvc_pkg::SEC_CYAN: begin
            red_in = cp; green_in = cq; blue_in = cv;
         end
         hsvc_pkg::SEC_BLUE: begin
            red_in = ct; green_in = cp; blue_in = cv;
         end
         hsvc_pkg::SEC_MAGENTA: begin
            red_in = cv; green_in = cp; blue_in = cq;
         end
         default: begin
            red_in = cv; green_in = cp; blue_in = cq;
         end
      endcase
      in_ready = !valid_ff || out_ready;
      load     = in_valid && in_ready;
      valid_in = in_ready ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         red_ff   <= red_in;
         green_ff <= green_in;
         blue_ff  <= blue_in;
      end
   end

   assign out_valid = valid_ff;
   assign red       = red_ff;
   assign green     = green_ff;
   assign blue      = blue_ff;

endmodule

// ===== rtl/hsv_to_rgb_converter.sv =====
// HSV to RGB converter, four register stages: wrap/clamp/sector, weights, products,
// round/route into the output register.
// Throughput: one transaction per cycle while rsp_if.ready holds; each stage has a valid bit and refills on stall.
// Reset (synchronous, active high) clears the stage valid bits; the pipe is then empty.
`timescale 1ns / 1ps
`include "hsv_to_rgb_converter_macros.svh"

module hsv_to_rgb_converter #(
   parameter int unsigned FRAC_BITS = 8
) (
   input  logic        clock,
   input  logic        reset,
   hsvc_req_if.sink    req_if,
   hsvc_rsp_if.source  rsp_if
);

   logic                    s1_valid, s1_ready, s2_valid, s2_ready, s3_valid, s3_ready;
   hsvc_pkg::sector_type    s1_sector, s2_sector, s3_sector;
   hsvc_pkg::rem_type       s1_rem;
   logic [FRAC_BITS:0]      s1_sat, s1_val, s2_oms;
   hsvc_pkg::chan_type      s2_cv, s3_cv;
   logic [FRAC_BITS+5:0]    s2_wq, s2_wt;
   logic [FRAC_BITS+4:0]    s2_v17;
   logic [FRAC_BITS+7:0]    s2_v255;
   logic [2*FRAC_BITS+10:0] s3_pq, s3_pt;
   logic [2*FRAC_BITS+8:0]  s3_pp;

   hsvc_sector #(.FRAC_BITS(FRAC_BITS)) u_sector (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_if.valid),
      .in_ready   (req_if.ready),
      .hue        (req_if.hue),
      .saturation (req_if.saturation),
      .brightness (req_if.brightness),
      .out_valid  (s1_valid),
      .out_ready  (s1_ready),
      .sector     (s1_sector),
      .rem        (s1_rem),
      .sat        (s1_sat),
      .val        (s1_val)
   );

   hsvc_terms #(.FRAC_BITS(FRAC_BITS)) u_terms (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid),
      .in_ready  (s1_ready),
      .sector    (s1_sector),
      .rem       (s1_rem),
      .sat       (s1_sat),
      .val       (s1_val),
      .out_valid (s2_valid),
      .out_ready (s2_ready),
      .sector_o  (s2_sector),
      .cv        (s2_cv),
      .wq        (s2_wq),
      .wt        (s2_wt),
      .oms       (s2_oms),
      .v17       (s2_v17),
      .v255      (s2_v255)
   );

   hsvc_mult #(.FRAC_BITS(FRAC_BITS)) u_mult (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s2_valid),
      .in_ready  (s2_ready),
      .sector    (s2_sector),
      .cv        (s2_cv),
      .wq        (s2_wq),
      .wt        (s2_wt),
      .oms       (s2_oms),
      .v17       (s2_v17),
      .v255      (s2_v255),
      .out_valid (s3_valid),
      .out_ready (s3_ready),
      .sector_o  (s3_sector),
      .cv_o      (s3_cv),
      .pq        (s3_pq),
      .pt        (s3_pt),
      .pp        (s3_pp)
   );

   hsvc_route #(.FRAC_BITS(FRAC_BITS)) u_route (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s3_valid),
      .in_ready  (s3_ready),
      .sector    (s3_sector),
      .cv        (s3_cv),
      .pq        (s3_pq),
      .pt        (s3_pt),
      .pp        (s3_pp),
      .out_valid (rsp_if.valid),
      .out_ready (rsp_if.ready),
      .red       (rsp_if.red_out),
      .green     (rsp_if.green_out),
      .blue      (rsp_if.blue_out)
   );

   // an empty output register must let the whole pipe move
   `HSVC_ASSERT(a_empty_out_accepts, clock, reset, !rsp_if.valid |-> req_if.ready, "req not ready with empty output stage")
   `HSVC_ASSERT_ALWAYS(a_reset_clears_out, clock, reset |=> !rsp_if.valid, "output valid after reset")
   `HSVC_ASSERT(a_out_from_stage3, clock, reset, $rose(rsp_if.valid) |-> $past(s3_valid), "output valid without a product stage transaction")

endmodule

// ===== tb/sv/hsv_to_rgb_converter_tb.sv =====
`timescale 1ns / 1ps

module hsv_to_rgb_converter_tb;

   localparam int unsigned FRAC_BITS    = 8;
   localparam int unsigned FULL_SCALE   = 255;
   localparam int unsigned RANDOM_ITEMS = 1250;

   typedef logic [FRAC_BITS:0] level_type;

   typedef struct packed {
      hsvc_pkg::hue_type hue;
      level_type         saturation;
      level_type         brightness;
   } hsv_color_type;

   typedef struct packed {
      hsvc_pkg::chan_type red;
      hsvc_pkg::chan_type green;
      hsvc_pkg::chan_type blue;
   } rgb_color_type;

   logic clock;
   logic reset;

   hsvc_req_if #(.FRAC_BITS(FRAC_BITS)) req_if ();
   hsvc_rsp_if rsp_if ();

   hsv_to_rgb_converter #(.FRAC_BITS(FRAC_BITS)) uut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if.sink),
      .rsp_if (rsp_if.source)
   );

   hsv_color_type pending_colors[$];
   rgb_color_type expected_rgb[$];
   int            mismatch_count = 0;

   // ---------------------------------------------------------------------
   // Prediction
   // ---------------------------------------------------------------------
   function automatic longint unsigned round_half_up(input longint unsigned num,
                                                     input longint unsigned den);
      return (2 * num + den) / (2 * den);
   endfunction

   function automatic rgb_color_type predict_rgb(input hsvc_pkg::hue_type hue_in,
                                                 input level_type sat_in,
                                                 input level_type bri_in);
      longint unsigned      unity, h, s, v, rem, den, base;
      longint unsigned      level, floor_c, falling, rising;
      hsvc_pkg::sector_type sector;
      rgb_color_type        rgb;
      unity = 64'd1 << FRAC_BITS;
      h = 64'(hue_in);
      s = 64'(sat_in);
      v = 64'(bri_in);
      if (h >= hsvc_pkg::HUE_TURN) h = h - hsvc_pkg::HUE_TURN;
      if (s > unity) s = unity;
      if (v > unity) v = unity;
      sector = hsvc_pkg::sector_type'(h / hsvc_pkg::SECTOR_DEG);
      rem = h % hsvc_pkg::SECTOR_DEG;
      // all four terms share the denominator 60 * unity^2
      den  = hsvc_pkg::SECTOR_DEG * unity * unity;
      base = FULL_SCALE * v;
      level   = round_half_up(base * hsvc_pkg::SECTOR_DEG * unity, den);
      floor_c = round_half_up(base * hsvc_pkg::SECTOR_DEG * (unity - s), den);
      falling = round_half_up(base * (hsvc_pkg::SECTOR_DEG * unity - s * rem), den);
      rising  = round_half_up(base * (hsvc_pkg::SECTOR_DEG * unity
                                      - s * (hsvc_pkg::SECTOR_DEG - rem)), den);
      case (sector)
         hsvc_pkg::SEC_RED: begin
            rgb.red   = hsvc_pkg::chan_type'(level);
            rgb.green = hsvc_pkg::chan_type'(rising);
            rgb.blue  = hsvc_pkg::chan_type'(floor_c);
         end
         hsvc_pkg::SEC_YELLOW: begin
            rgb.red   = hsvc_pkg::chan_type'(falling);
            rgb.green = hsvc_pkg::chan_type'(level);
            rgb.blue  = hsvc_pkg::chan_type'(floor_c);
         end
         hsvc_pkg::SEC_GREEN: begin
            rgb.red   = hsvc_pkg::chan_type'(floor_c);
            rgb.green = hsvc_pkg::chan_type'(level);
            rgb.blue  = hsvc_pkg::chan_type'(rising);
         end
         hsvc_pkg::SEC_CYAN: begin
            rgb.red   = hsvc_pkg::chan_type'(floor_c);
            rgb.green = hsvc_pkg::chan_type'(falling);
            rgb.blue  = hsvc_pkg::chan_type'(level);
         end
         hsvc_pkg::SEC_BLUE: begin
            rgb.red   = hsvc_pkg::chan_type'(rising);
            rgb.green = hsvc_pkg::chan_type'(floor_c);
            rgb.blue  = hsvc_pkg::chan_type'(level);
         end
         default: begin
            rgb.red   = hsvc_pkg::chan_type'(level);
            rgb.green = hsvc_pkg::chan_type'(floor_c);
            rgb.blue  = hsvc_pkg::chan_type'(falling);
         end
      endcase
      return rgb;
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------
   task automatic add_color(input int unsigned h, input int unsigned s, input int unsigned b);
      hsv_color_type c;
      c.hue        = hsvc_pkg::hue_type'(h);
      c.saturation = level_type'(s);
      c.brightness = level_type'(b);
      pending_colors.push_back(c);
   endtask

   function automatic int unsigned random_level();
      case ($urandom_range(0, 9))
         0:       return 0;
         1:       return 1 << FRAC_BITS;
         2:       return $urandom_range((1 << FRAC_BITS) + 1, (1 << (FRAC_BITS + 1)) - 1);
         default: return $urandom_range(0, 1 << FRAC_BITS);
      endcase
   endfunction

   function automatic int unsigned random_hue();
      case ($urandom_range(0, 9))
         0:       return $urandom_range(hsvc_pkg::HUE_TURN + 1, 511);
         1:       return hsvc_pkg::SECTOR_DEG * $urandom_range(0, 6);
         2:       return hsvc_pkg::SECTOR_DEG * $urandom_range(1, 6) - 1;
         default: return $urandom_range(0, hsvc_pkg::HUE_TURN);
      endcase
   endfunction

   // ---------------------------------------------------------------------
   // Clock
   // ---------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Driver: bursts of random length separated by random gaps
   // ---------------------------------------------------------------------
   int            burst_left = 0;
   int            gap_left   = 0;
   hsv_color_type next_color;

   initial begin
      req_if.valid      = 1'b0;
      req_if.hue        = '0;
      req_if.saturation = '0;
      req_if.brightness = '0;
      rsp_if.ready      = 1'b0;
   end

   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else begin
         if (req_if.valid && req_if.ready)
            expected_rgb.push_back(predict_rgb(req_if.hue, req_if.saturation,
                                               req_if.brightness));
         if (!req_if.valid || req_if.ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_if.valid <= 1'b0;
            end else if (pending_colors.size() > 0) begin
               if (burst_left == 0) burst_left = $urandom_range(1, 24);
               next_color = pending_colors.pop_front();
               req_if.hue        <= next_color.hue;
               req_if.saturation <= next_color.saturation;
               req_if.brightness <= next_color.brightness;
               req_if.valid      <= 1'b1;
               burst_left--;
               // about a third of bursts run straight into the next one
               if (burst_left == 0)
                  gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Receiver: stall pattern changes mode every so often
   // ---------------------------------------------------------------------
   int       stall_mode  = 0;
   int       mode_left   = 0;
   int       mask_phase  = 0;
   bit [7:0] stall_mask  = 8'hFF;

   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            mode_left  = $urandom_range(40, 200);
            stall_mask = 8'($urandom_range(1, 255));
         end
         mode_left--;
         mask_phase = (mask_phase + 1) % 8;
         case (stall_mode)
            0:       rsp_if.ready <= 1'b1;
            1:       rsp_if.ready <= stall_mask[mask_phase];
            default: rsp_if.ready <= ($urandom_range(0, 1) == 1);
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Monitor
   // ---------------------------------------------------------------------
   rgb_color_type wanted_rgb;

   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_rgb.size() == 0) begin
            $error("unexpected transaction on rsp: red_out %0d green_out %0d blue_out %0d",
                   rsp_if.red_out, rsp_if.green_out, rsp_if.blue_out);
            mismatch_count++;
         end else begin
            wanted_rgb = expected_rgb.pop_front();
            if (rsp_if.red_out !== wanted_rgb.red) begin
               $error("red_out: expected %0d, got %0d", wanted_rgb.red, rsp_if.red_out);
               mismatch_count++;
            end
            if (rsp_if.green_out !== wanted_rgb.green) begin
               $error("green_out: expected %0d, got %0d", wanted_rgb.green, rsp_if.green_out);
               mismatch_count++;
            end
            if (rsp_if.blue_out !== wanted_rgb.blue) begin
               $error("blue_out: expected %0d, got %0d", wanted_rgb.blue, rsp_if.blue_out);
               mismatch_count++;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------
   initial begin
      reset = 1'b1;

      // sector edges and both ends of every field
      add_color(0,   256, 256);
      add_color(59,  256, 256);
      add_color(60,  256, 256);
      add_color(119, 256, 256);
      add_color(120, 256, 256);
      add_color(180, 256, 256);
      add_color(240, 256, 256);
      add_color(300, 256, 256);
      add_color(359, 256, 256);
      add_color(360, 256, 256);    // full turn
      add_color(361, 200, 256);    // wraps past full turn
      add_color(511, 128, 200);
      add_color(90,  0,   256);    // grey
      add_color(200, 256, 0);      // black
      add_color(30,  511, 256);    // saturation clamped
      add_color(270, 256, 511);    // brightness clamped
      add_color(150, 257, 257);
      add_color(0,   0,   128);    // 127.5 rounds up
      add_color(330, 128, 128);
      add_color(45,  1,   1);
      add_color(210, 255, 255);
      add_color(100, 170, 86);
      add_color(0,   0,   0);

      for (int i = 0; i < RANDOM_ITEMS; i++)
         add_color(random_hue(), random_level(), random_level());

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      while (pending_colors.size() != 0 || req_if.valid) @(posedge clock);
      while (expected_rgb.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      if (mismatch_count == 0)
         $display("** hsv_to_rgb_converter: PASSED **");
      else
         $display("** hsv_to_rgb_converter: FAILED **");
      $finish;
   end

   initial begin
      #2000000;
      $display("timeout with %0d transactions still expected", expected_rgb.size());
      $display("** hsv_to_rgb_converter: FAILED **");
      $finish;
   end

endmodule

// ===== hsv_to_rgb_converter.f =====
+incdir+rtl
rtl/hsvc_pkg.sv
rtl/hsvc_channels.sv
rtl/hsvc_sector.sv
rtl/hsvc_terms.sv
rtl/hsvc_mult.sv
rtl/hsvc_route.sv
rtl/hsv_to_rgb_converter.sv
tb/sv/hsv_to_rgb_converter_tb.sv
